// File: rtl/chull_pkg.sv
// Types shared by the convex hull block: port words and the controller/datapath
// command and status groups. No dependencies.
package chull_pkg;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [6:0]         vertex_number;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic load;
    logic sort_rd;
    logic sort_latch;
    logic scan;
    logic sort_write;
    logic hull_init;
    logic fetch_ord;
    logic fetch_pt;
    logic latch_cur;
    logic stack_rd_top;
    logic diff;
    logic mul;
    logic pop;
    logic push;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic test_ok;
    logic clockwise;
    logic hull_done;
    logic emit_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/chull_dp.sv
// Datapath of the convex hull block: point store, rank sort, hull stack,
// cross product unit and output register. Uses chull_pkg.
module chull_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  chull_pkg::cmd_t   cmd,
  input  chull_pkg::point_t point,
  output chull_pkg::stat_t  stat,
  output logic              vertex_valid,
  input  logic              vertex_stall,
  output chull_pkg::vertex_t vertex
);
  import chull_pkg::*;

  localparam int UB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = $clog2(2 * MAX_POINTS);
  localparam int PW = 2 * UB + 2;

  typedef logic signed [UB-1:0] coord_t;
  typedef logic signed [UB:0]   diff_t;
  typedef logic signed [PW-1:0] prod_t;

  coord_t          mem_x [MAX_POINTS];
  coord_t          mem_y [MAX_POINTS];
  logic [IW-1:0]   mem_ord [MAX_POINTS];
  logic [IW-1:0]   stk_idx [2*MAX_POINTS];
  coord_t          stk_x [2*MAX_POINTS];
  coord_t          stk_y [2*MAX_POINTS];

  logic [CW-1:0] count;
  logic [IW-1:0] n_last, i, j, jd, rank, p, rd_addr, ord_rd;
  logic          scan_d, upper, less;
  coord_t        rd_x, rd_y, pi_x, pi_y;
  logic [DW-1:0] depth, floor_d, e, ecount, st_addr, dm1;
  logic [IW-1:0] cur_idx, stk_rd_idx;
  coord_t        top_x, top_y, cur_x, cur_y, stk_rd_x, stk_rd_y;
  diff_t         ax, ay, px, py;
  prod_t         ax_w, ay_w, px_w, py_w, pr1, pr2;

  assign n_last = IW'(count - 1'b1);
  assign dm1    = depth - 1'b1;

  // store, one read port
  always_comb begin
    if (cmd.sort_rd)   rd_addr = i;
    else if (cmd.scan) rd_addr = j;
    else               rd_addr = ord_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(MAX_POINTS))) begin
      mem_x[count[IW-1:0]] <= point.point_x[UB-1:0];
      mem_y[count[IW-1:0]] <= point.point_y[UB-1:0];
    end
    if (cmd.sort_rd || cmd.scan || cmd.fetch_pt) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_write) mem_ord[rank] <= i;
    if (cmd.fetch_ord)  ord_rd <= mem_ord[p];
  end

  // stack
  assign st_addr = cmd.emit_rd ? e : DW'(depth - 2'd2);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_idx[depth] <= cur_idx;
      stk_x[depth]   <= cur_x;
      stk_y[depth]   <= cur_y;
    end
    if (cmd.stack_rd_top || cmd.emit_rd) begin
      stk_rd_idx <= stk_idx[st_addr];
      stk_rd_x   <= stk_x[st_addr];
      stk_rd_y   <= stk_y[st_addr];
    end
  end

  // rank of point i: count points ordered before it by (x, y, arrival)
  assign less = (rd_x < pi_x) ||
                ((rd_x == pi_x) && ((rd_y < pi_y) || ((rd_y == pi_y) && (jd < i))));

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      scan_d <= 1'b0;
    end else begin
      scan_d <= cmd.scan;
      if (cmd.finish)
        count <= '0;
      else if (cmd.load && (count < CW'(MAX_POINTS)))
        count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) i <= '0;
    if (cmd.sort_write) i <= i + 1'b1;
    if (cmd.sort_latch) begin
      pi_x <= rd_x;
      pi_y <= rd_y;
      j    <= '0;
      rank <= '0;
    end
    if (cmd.scan) begin
      j  <= j + 1'b1;
      jd <= j;
    end
    if (scan_d && less) rank <= rank + 1'b1;
  end

  // hull passes
  always_ff @(posedge clk) begin
    if (cmd.hull_init) begin
      depth   <= '0;
      p       <= '0;
      upper   <= 1'b0;
      floor_d <= '0;
    end
    if (cmd.latch_cur) begin
      cur_x   <= rd_x;
      cur_y   <= rd_y;
      cur_idx <= ord_rd;
    end
    if (cmd.diff) begin
      ax <= diff_t'(top_x) - diff_t'(stk_rd_x);
      ay <= diff_t'(top_y) - diff_t'(stk_rd_y);
      px <= diff_t'(cur_x) - diff_t'(stk_rd_x);
      py <= diff_t'(cur_y) - diff_t'(stk_rd_y);
    end
    if (cmd.mul) begin
      pr1 <= ax_w * py_w;
      pr2 <= px_w * ay_w;
    end
    if (cmd.pop) begin
      depth   <= dm1;
      top_x   <= stk_rd_x;
      top_y   <= stk_rd_y;
    end
    if (cmd.push) begin
      depth   <= depth + 1'b1;
      top_x   <= cur_x;
      top_y   <= cur_y;
      if (!upper) begin
        if (p == n_last) begin
          upper   <= 1'b1;
          floor_d <= depth + 1'b1;
          p       <= n_last - 1'b1;
        end else begin
          p <= p + 1'b1;
        end
      end else begin
        p <= p - 1'b1;
      end
    end
  end

  assign ax_w = prod_t'(ax);
  assign ay_w = prod_t'(ay);
  assign px_w = prod_t'(px);
  assign py_w = prod_t'(py);

  // emission
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      e <= '0;
      if (count == CW'(1))
        ecount <= DW'(1);
      else if (dm1 > DW'(MAX_POINTS))
        ecount <= DW'(MAX_POINTS);
      else
        ecount <= dm1;
    end
    if (cmd.emit_load) e <= e + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      vertex.vertex_number <= 7'(stk_rd_idx) + 7'd1;
      vertex.vertex_x      <= 16'(stk_rd_x);
      vertex.vertex_y      <= 16'(stk_rd_y);
      vertex.last_vertex   <= (DW'(e + 1'b1) == ecount);
    end
  end

  assign stat.j_last    = (j == n_last);
  assign stat.i_last    = (i == n_last);
  assign stat.test_ok   = (depth > floor_d) && (depth > DW'(1));
  assign stat.clockwise = (pr1 < pr2);
  assign stat.hull_done = upper ? (p == '0) : ((p == n_last) && (count == CW'(1)));
  assign stat.emit_done = (e == ecount);
  assign stat.out_free  = !vertex_valid || !vertex_stall;

endmodule

// File: rtl/chull_ctrl.sv
// Sequencer of the convex hull block: load, sort, hull passes and emission.
// Drives chull_dp through the command group of chull_pkg.
module chull_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             last_point,
  input  chull_pkg::stat_t stat,
  output chull_pkg::cmd_t  cmd,
  output logic             busy
);
  import chull_pkg::*;

  localparam logic [4:0] LOAD    = 5'd0;
  localparam logic [4:0] SORT_I  = 5'd1;
  localparam logic [4:0] SORT_IW = 5'd2;
  localparam logic [4:0] SORT_J  = 5'd3;
  localparam logic [4:0] SORT_JE = 5'd4;
  localparam logic [4:0] SORT_W  = 5'd5;
  localparam logic [4:0] H_F1    = 5'd6;
  localparam logic [4:0] H_F2    = 5'd7;
  localparam logic [4:0] H_F3    = 5'd8;
  localparam logic [4:0] H_TEST  = 5'd9;
  localparam logic [4:0] H_TW    = 5'd10;
  localparam logic [4:0] H_MUL   = 5'd11;
  localparam logic [4:0] H_CMP   = 5'd12;
  localparam logic [4:0] H_PUSH  = 5'd13;
  localparam logic [4:0] E_INIT  = 5'd14;
  localparam logic [4:0] E_RD    = 5'd15;
  localparam logic [4:0] E_W     = 5'd16;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= LOAD;
    else     state <= state_next;
  end

  assign busy = (state != LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      LOAD: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (last_point) state_next = SORT_I;
        end
      end
      SORT_I: begin
        cmd.sort_rd = 1'b1;
        state_next  = SORT_IW;
      end
      SORT_IW: begin
        cmd.sort_latch = 1'b1;
        state_next     = SORT_J;
      end
      SORT_J: begin
        cmd.scan = 1'b1;
        if (stat.j_last) state_next = SORT_JE;
      end
      SORT_JE: state_next = SORT_W;
      SORT_W: begin
        cmd.sort_write = 1'b1;
        if (stat.i_last) begin
          cmd.hull_init = 1'b1;
          state_next    = H_F1;
        end else begin
          state_next = SORT_I;
        end
      end
      H_F1: begin
        cmd.fetch_ord = 1'b1;
        state_next    = H_F2;
      end
      H_F2: begin
        cmd.fetch_pt = 1'b1;
        state_next   = H_F3;
      end
      H_F3: begin
        cmd.latch_cur = 1'b1;
        state_next    = H_TEST;
      end
      H_TEST: begin
        if (stat.test_ok) begin
          cmd.stack_rd_top = 1'b1;
          state_next       = H_TW;
        end else begin
          state_next = H_PUSH;
        end
      end
      H_TW: begin
        cmd.diff   = 1'b1;
        state_next = H_MUL;
      end
      H_MUL: begin
        cmd.mul    = 1'b1;
        state_next = H_CMP;
      end
      H_CMP: begin
        if (stat.clockwise) begin
          cmd.pop    = 1'b1;
          state_next = H_TEST;
        end else begin
          state_next = H_PUSH;
        end
      end
      H_PUSH: begin
        cmd.push   = 1'b1;
        state_next = stat.hull_done ? E_INIT : H_F1;
      end
      E_INIT: begin
        cmd.emit_init = 1'b1;
        state_next    = E_RD;
      end
      E_RD: begin
        if (stat.emit_done) begin
          cmd.finish = 1'b1;
          state_next = LOAD;
        end else if (stat.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = E_W;
        end
      end
      E_W: begin
        cmd.emit_load = 1'b1;
        state_next    = E_RD;
      end
      default: state_next = LOAD;
    endcase
  end

endmodule

// File: rtl/convex_hull_monotone_chain.sv
// Convex hull (monotone chain) of up to MAX_POINTS signed points. Points are taken one
// word per cycle while idle; the word with last_point set closes the set, and the block
// then stalls its input while it ranks the points by (x, y, arrival) through one store
// read port, builds the lower and upper chains on a stack, and emits the vertices
// counterclockwise through an output register, each once the register is free. Points
// beyond MAX_POINTS are dropped. Uses chull_ctrl, chull_dp, chull_pkg.
module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  chull_pkg::point_t  point,
  output logic               vertex_valid,
  input  logic               vertex_stall,
  output chull_pkg::vertex_t vertex
);
  import chull_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  chull_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (point_valid && !busy),
    .last_point (point.last_point),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  chull_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .point        (point),
    .stat         (stat),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex)
  );

  assign point_stall = busy;

endmodule

// File: rtl/chull_check.sv
// Port checker for convex_hull_monotone_chain, bound to the top level.
// Uses chull_pkg.
module chull_check (
  input logic               clk,
  input logic               rst,
  input logic               point_valid,
  input logic               point_stall,
  input chull_pkg::point_t  point,
  input logic               vertex_valid,
  input logic               vertex_stall,
  input chull_pkg::vertex_t vertex
);
  import chull_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
    else $error("vertex word changed while stalled");

  // closing point starts the computation
  a_start: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && point.last_point |=> point_stall)
    else $error("input not stalled after last point");

  // no word offered straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !vertex_valid)
    else $error("vertex word offered after reset");

  a_num: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> vertex.vertex_number != 7'd0)
    else $error("vertex number zero");

endmodule

bind convex_hull_monotone_chain chull_check u_chull_check (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_stall  (point_stall),
  .point        (point),
  .vertex_valid (vertex_valid),
  .vertex_stall (vertex_stall),
  .vertex       (vertex)
);
